/* sv/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define TSB_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be seen at a clock edge outside reset.
`define TSB_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* sv/tsb_pkg.sv */
package tsb_pkg;

    // Default sizes of the timer bank.
    localparam int NUM_TIMERS_DEF  = 32;
    localparam int COUNT_WIDTH_DEF = 32;

    // Fixed field widths of the transactions.
    localparam int INDEX_WIDTH  = 5;
    localparam int VALUE_WIDTH  = 32;
    localparam int UPTIME_WIDTH = 64;

    // Transaction kinds carried on the mode input.
    localparam logic MODE_TICK    = 1'b0;
    localparam logic MODE_PROGRAM = 1'b1;

    // Outcome of updating one entry during a tick walk.
    typedef struct packed {
        logic write_back;
        logic fire;
    } upd_ctrl_t;

endpackage

/* sv/software_timer_bank_core.sv */
// Program transaction: written on accept, gives no result, busy stays low.
// Tick transaction: busy while the walk runs; an expiry result for entry k is registered
// after entry k is read and processed, and the final uptime result follows the last entry.
// The walk reads one RAM entry per cycle, then closes; no new transaction is taken while busy.
// Reset (rst_n low, asynchronous) clears uptime, control and per-entry valid bits;
// the entry RAM itself is not cleared. Results are strobed and cannot be stalled.
module software_timer_bank_core #(
    parameter int NUM_TIMERS  = tsb_pkg::NUM_TIMERS_DEF,
    parameter int COUNT_WIDTH = tsb_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                mode,
    input  logic [tsb_pkg::INDEX_WIDTH-1:0]     timer_index,
    input  logic                                enable_value,
    input  logic                                notify_value,
    input  logic [tsb_pkg::VALUE_WIDTH-1:0]     start_count,
    input  logic [tsb_pkg::VALUE_WIDTH-1:0]     reload_period,
    output logic                                strobe,
    output logic                                fired,
    output logic [tsb_pkg::INDEX_WIDTH-1:0]     fired_index,
    output logic [tsb_pkg::UPTIME_WIDTH-1:0]    uptime_now,
    output logic                                last
);

    import tsb_pkg::*;

    localparam int AW      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int ENTRY_W = 2 + 2 * COUNT_WIDTH;
    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_TIMERS - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_FINAL = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic                    issue_reg, issue_next;
    logic [AW-1:0]           rd_idx_reg, rd_idx_next;
    logic                    proc_valid_reg, proc_valid_next;
    logic [AW-1:0]           proc_idx_reg;
    logic                    proc_entry_valid_reg;
    logic [NUM_TIMERS-1:0]   valid_reg, valid_next;
    logic [UPTIME_WIDTH-1:0] uptime_reg, uptime_next;
    logic                    strobe_reg, strobe_next;
    logic                    fired_reg, fired_next;
    logic                    last_reg, last_next;
    logic [INDEX_WIDTH-1:0]  fired_index_reg, fired_index_next;

    logic                    accept;
    logic                    prog_accept;
    logic                    tick_accept;
    logic                    prog_in_range;
    logic [63:0]             prog_idx_ext;
    logic [AW-1:0]           prog_addr;
    logic [63:0]             count_ext;
    logic [63:0]             period_ext;
    logic [63:0]             proc_idx_ext;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [ENTRY_W-1:0]      ram_wdata;
    logic [ENTRY_W-1:0]      ram_rdata;
    logic [ENTRY_W-1:0]      entry;
    logic [COUNT_WIDTH-1:0]  count_next;
    upd_ctrl_t               upd_ctrl;
    logic                    walk_done;

    // Transaction decode.
    assign accept        = start && !busy;
    assign prog_accept   = accept && (mode == MODE_PROGRAM);
    assign tick_accept   = accept && (mode == MODE_TICK);
    assign prog_idx_ext  = 64'(timer_index);
    assign prog_in_range = prog_idx_ext < 64'(NUM_TIMERS);
    assign prog_addr     = prog_idx_ext[AW-1:0];
    assign count_ext     = 64'(start_count);
    assign period_ext    = 64'(reload_period);
    assign proc_idx_ext  = 64'(proc_idx_reg);

    // Entry RAM: {enable, notify, count, period}.
    tsb_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(NUM_TIMERS)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(rd_idx_reg),
        .rdata(ram_rdata)
    );

    // An entry never written since reset reads as all zero.
    assign entry = proc_entry_valid_reg ? ram_rdata : '0;

    tsb_update #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_update (
        .enable    (entry[ENTRY_W-1]),
        .notify    (entry[ENTRY_W-2]),
        .count     (entry[2*COUNT_WIDTH-1:COUNT_WIDTH]),
        .period    (entry[COUNT_WIDTH-1:0]),
        .count_next(count_next),
        .ctrl      (upd_ctrl)
    );

    // Write port: programming while idle, write-back while walking.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = proc_idx_reg;
        ram_wdata = {entry[ENTRY_W-1:ENTRY_W-2], count_next, entry[COUNT_WIDTH-1:0]};
        valid_next = valid_reg;
        if (prog_accept && prog_in_range)
        begin
            ram_we    = 1'b1;
            ram_waddr = prog_addr;
            ram_wdata = {enable_value, notify_value, count_ext[COUNT_WIDTH-1:0],
                         period_ext[COUNT_WIDTH-1:0]};
            valid_next[prog_addr] = 1'b1;
        end
        else if (proc_valid_reg && upd_ctrl.write_back)
        begin
            ram_we = 1'b1;
        end
    end

    assign walk_done = proc_valid_reg && (proc_idx_reg == LAST_IDX);

    // Walk sequencer: read issue one entry per cycle, process each in the cycle after its issue.
    always_comb
    begin
        state_next      = state_reg;
        issue_next      = issue_reg;
        rd_idx_next     = rd_idx_reg;
        proc_valid_next = 1'b0;
        uptime_next     = uptime_reg;
        strobe_next     = 1'b0;
        fired_next      = 1'b0;
        last_next       = 1'b0;
        fired_index_next = proc_idx_ext[INDEX_WIDTH-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (tick_accept)
                begin
                    state_next  = ST_WALK;
                    issue_next  = 1'b1;
                    rd_idx_next = '0;
                    uptime_next = uptime_reg + UPTIME_WIDTH'(1);
                end
            end
            ST_WALK:
            begin
                if (issue_reg)
                begin
                    proc_valid_next = 1'b1;
                    rd_idx_next     = rd_idx_reg + AW'(1);
                    if (rd_idx_reg == LAST_IDX)
                    begin
                        issue_next = 1'b0;
                    end
                end
                if (proc_valid_reg && upd_ctrl.fire)
                begin
                    strobe_next = 1'b1;
                    fired_next  = 1'b1;
                end
                if (walk_done)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                state_next       = ST_IDLE;
                strobe_next      = 1'b1;
                last_next        = 1'b1;
                fired_index_next = '0;
            end
            default:
            begin
                state_next = ST_IDLE;
                issue_next = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            issue_reg      <= 1'b0;
            rd_idx_reg     <= '0;
            proc_valid_reg <= 1'b0;
            valid_reg      <= '0;
            uptime_reg     <= '0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_reg      <= issue_next;
            rd_idx_reg     <= rd_idx_next;
            proc_valid_reg <= proc_valid_next;
            valid_reg      <= valid_next;
            uptime_reg     <= uptime_next;
            strobe_reg     <= strobe_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        proc_idx_reg         <= rd_idx_reg;
        proc_entry_valid_reg <= valid_reg[rd_idx_reg];
        fired_reg            <= fired_next;
        last_reg             <= last_next;
        fired_index_reg      <= fired_index_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign strobe      = strobe_reg;
    assign fired       = fired_reg;
    assign last        = last_reg;
    assign fired_index = fired_index_reg;
    assign uptime_now  = uptime_reg;

endmodule

/* sv/tsb_ram.sv */
module tsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port, registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/tsb_update.sv */
module tsb_update #(
    parameter int COUNT_WIDTH = tsb_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   enable,
    input  logic                   notify,
    input  logic [COUNT_WIDTH-1:0] count,
    input  logic [COUNT_WIDTH-1:0] period,
    output logic [COUNT_WIDTH-1:0] count_next,
    output tsb_pkg::upd_ctrl_t     ctrl
);

    import tsb_pkg::*;

    logic active;
    logic expiring;

    // An enabled entry with a nonzero count counts down; reaching zero reloads the period.
    assign active   = enable && (count != '0);
    assign expiring = active && (count == COUNT_WIDTH'(1));

    always_comb
    begin
        count_next      = count - COUNT_WIDTH'(1);
        ctrl.write_back = active;
        ctrl.fire       = expiring && notify;
        if (expiring)
        begin
            count_next = period;
        end
    end

endmodule

/* sv/tsb_checker.sv */
`include "assert_macros.svh"

module tsb_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic mode,
    input logic strobe,
    input logic fired,
    input logic last
);

    import tsb_pkg::*;

    // A program transaction completes at once and leaves the block free.
    `TSB_ASSERT(a_prog_no_busy, clk, rst_n, (start && !busy && mode == MODE_PROGRAM) |=> !busy, "program transaction raised busy")
    // A tick transaction starts a walk.
    `TSB_ASSERT(a_tick_busy, clk, rst_n, (start && !busy && mode == MODE_TICK) |=> busy, "tick transaction did not raise busy")
    // The end of a walk is marked by the final uptime result.
    `TSB_ASSERT(a_end_final, clk, rst_n, $fell(busy) |-> (strobe && last), "walk ended without final result")
    // The final result is never an expiry report.
    `TSB_ASSERT_NEVER(a_last_fired, clk, rst_n, strobe && last && fired, "final result flagged as expiry")
    // Outside a walk only the final result may appear.
    `TSB_ASSERT(a_idle_last, clk, rst_n, (strobe && !busy) |-> last, "expiry result while idle")

endmodule

bind software_timer_bank_core tsb_checker u_tsb_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .mode  (mode),
    .strobe(strobe),
    .fired (fired),
    .last  (last)
);

/* dv/tb_software_timer_bank_core.sv */
module tb_software_timer_bank_core;
    timeunit 1ns;
    timeprecision 1ps;

    import tsb_pkg::*;

    localparam int N_TIMERS   = NUM_TIMERS_DEF;
    localparam int C_WIDTH    = COUNT_WIDTH_DEF;
    localparam int CLK_HALF   = 10;
    localparam int IDLE_LIMIT = 2000;
    localparam int N_RANDOM   = 500;
    localparam int N_DIRECTED = 20;

    // One command transaction, with an optional hand-written expectation for ticks.
    typedef struct packed {
        logic                     mode;
        logic [INDEX_WIDTH-1:0]   index;
        logic                     enable;
        logic                     notify;
        logic [VALUE_WIDTH-1:0]   count;
        logic [VALUE_WIDTH-1:0]   period;
        logic                     typed;
        logic [N_TIMERS-1:0]      fire_mask;
        logic [UPTIME_WIDTH-1:0]  uptime;
    } timer_cmd_t;

    // One strobed result transaction.
    typedef struct packed {
        logic                     fired;
        logic [INDEX_WIDTH-1:0]   index;
        logic [UPTIME_WIDTH-1:0]  uptime;
        logic                     last;
    } timer_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic                     mode = MODE_TICK;
    logic [INDEX_WIDTH-1:0]   timer_index = '0;
    logic                     enable_value = 1'b0;
    logic                     notify_value = 1'b0;
    logic [VALUE_WIDTH-1:0]   start_count = '0;
    logic [VALUE_WIDTH-1:0]   reload_period = '0;
    logic                     strobe;
    logic                     fired;
    logic [INDEX_WIDTH-1:0]   fired_index;
    logic [UPTIME_WIDTH-1:0]  uptime_now;
    logic                     last;

    // Shadow copy of the timer bank.
    logic [UPTIME_WIDTH-1:0]  bank_uptime = '0;
    logic                     bank_enable [N_TIMERS];
    logic                     bank_notify [N_TIMERS];
    logic [C_WIDTH-1:0]       bank_count  [N_TIMERS];
    logic [C_WIDTH-1:0]       bank_period [N_TIMERS];

    timer_result_t            tick_results [$];
    timer_result_t            pending_results [$];

    int                       mismatches = 0;
    int                       idle_cycles = 0;
    int                       ticks_sent = 0;
    int                       programs_sent = 0;
    int                       expiries_seen = 0;
    int                       closings_seen = 0;

    // Directed transactions: extremes, one-shot and periodic entries, zero count,
    // disabled and silent entries. Ticks with an obvious outcome carry it inline.
    timer_cmd_t directed_rows [N_DIRECTED] = '{
        '{MODE_TICK,    5'd0,  1'b0, 1'b0, 32'h0,         32'h0,         1'b1, 32'h0,
          64'd1},
        '{MODE_PROGRAM, 5'd0,  1'b1, 1'b1, 32'h1,         32'h0,         1'b0, 32'h0, 64'd0},
        '{MODE_PROGRAM, 5'd31, 1'b1, 1'b1, 32'h1,         32'h2,         1'b0, 32'h0, 64'd0},
        '{MODE_TICK,    5'd0,  1'b0, 1'b0, 32'h0,         32'h0,         1'b1, 32'h8000_0001,
          64'd2},
        '{MODE_TICK,    5'd0,  1'b0, 1'b0, 32'h0,         32'h0,         1'b1, 32'h0,
          64'd3},
        '{MODE_TICK,    5'd31, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000,
          64'd4},
        '{MODE_PROGRAM, 5'd5,  1'b1, 1'b1, 32'h0,         32'h7,         1'b0, 32'h0, 64'd0},
        '{MODE_PROGRAM, 5'd6,  1'b0, 1'b1, 32'h1,         32'h1,         1'b0, 32'h0, 64'd0},
        '{MODE_PROGRAM, 5'd7,  1'b1, 1'b0, 32'h1,         32'h1,         1'b0, 32'h0, 64'd0},
        '{MODE_TICK,    5'd0,  1'b0, 1'b0, 32'h0,         32'h0,         1'b1, 32'h0,
          64'd5},
        '{MODE_PROGRAM, 5'd31, 1'b0, 1'b0, 32'h0,         32'h0,         1'b0, 32'h0, 64'd0},
        '{MODE_PROGRAM, 5'd10, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 64'd0},
        '{MODE_PROGRAM, 5'd11, 1'b1, 1'b1, 32'h1,         32'hFFFF_FFFF, 1'b0, 32'h0, 64'd0},
        '{MODE_TICK,    5'd0,  1'b0, 1'b0, 32'h0,         32'h0,         1'b1, 32'h0000_0800,
          64'd6},
        '{MODE_PROGRAM, 5'd12, 1'b1, 1'b1, 32'h2,         32'h1,         1'b0, 32'h0, 64'd0},
        '{MODE_TICK,    5'd0,  1'b0, 1'b0, 32'h0,         32'h0,         1'b0, 32'h0, 64'd0},
        '{MODE_TICK,    5'd0,  1'b0, 1'b0, 32'h0,         32'h0,         1'b0, 32'h0, 64'd0},
        '{MODE_PROGRAM, 5'd6,  1'b1, 1'b1, 32'h1,         32'h0,         1'b0, 32'h0, 64'd0},
        '{MODE_PROGRAM, 5'd20, 1'b1, 1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'h0, 64'd0},
        '{MODE_TICK,    5'd0,  1'b0, 1'b0, 32'h0,         32'h0,         1'b0, 32'h0, 64'd0}
    };

    software_timer_bank_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .timer_index   (timer_index),
        .enable_value  (enable_value),
        .notify_value  (notify_value),
        .start_count   (start_count),
        .reload_period (reload_period),
        .strobe        (strobe),
        .fired         (fired),
        .fired_index   (fired_index),
        .uptime_now    (uptime_now),
        .last          (last)
    );

    // Free-running clock.
    always
    begin
        #CLK_HALF clk = ~clk;
    end

    // Applies one accepted transaction to the shadow bank; a tick leaves its
    // expiry reports and closing result in tick_results.
    task automatic advance_bank(input timer_cmd_t cmd);
        int k;
        tick_results.delete();
        if (cmd.mode == MODE_PROGRAM) begin
            if (int'(cmd.index) < N_TIMERS) begin
                bank_enable[cmd.index] = cmd.enable;
                bank_notify[cmd.index] = cmd.notify;
                bank_count[cmd.index]  = C_WIDTH'(cmd.count);
                bank_period[cmd.index] = C_WIDTH'(cmd.period);
            end
        end
        else begin
            bank_uptime = bank_uptime + 1'b1;
            for (k = 0; k < N_TIMERS; k++) begin
                if (bank_enable[k] && bank_count[k] != '0) begin
                    bank_count[k] = bank_count[k] - 1'b1;
                    if (bank_count[k] == '0) begin
                        if (bank_notify[k]) begin
                            tick_results.push_back('{1'b1, INDEX_WIDTH'(k), bank_uptime, 1'b0});
                        end
                        bank_count[k] = bank_period[k];
                    end
                end
            end
            tick_results.push_back('{1'b0, '0, bank_uptime, 1'b1});
        end
    endtask

    // Drives one transaction after a random gap and waits for it to be taken.
    task automatic send_command(input timer_cmd_t cmd);
        int gap;
        int k;
        gap = $urandom_range(0, 8);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        mode          <= cmd.mode;
        timer_index   <= cmd.index;
        enable_value  <= cmd.enable;
        notify_value  <= cmd.notify;
        start_count   <= cmd.count;
        reload_period <= cmd.period;
        @(posedge clk);
        while (busy) @(posedge clk);

        // Accepted at this edge.
        advance_bank(cmd);
        if (cmd.mode == MODE_TICK) begin
            ticks_sent++;
            if (cmd.typed) begin
                for (k = 0; k < N_TIMERS; k++) begin
                    if (cmd.fire_mask[k]) begin
                        pending_results.push_back('{1'b1, INDEX_WIDTH'(k), cmd.uptime, 1'b0});
                    end
                end
                pending_results.push_back('{1'b0, '0, cmd.uptime, 1'b1});
            end
            else begin
                foreach (tick_results[k]) pending_results.push_back(tick_results[k]);
            end
        end
        else begin
            programs_sent++;
        end
    endtask

    // Mostly short counts so that entries expire often; now and then a full-width
    // value so that every bit is exercised.
    function automatic logic [VALUE_WIDTH-1:0] draw_count(input int zero_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < zero_pct) begin
            return '0;
        end
        else if (r < zero_pct + 12) begin
            return $urandom;
        end
        return VALUE_WIDTH'($urandom_range(1, 6));
    endfunction

    task automatic note_mismatch(input string what, input timer_result_t want,
                                 input timer_result_t have);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s: expected fired=%0d index=%0d uptime=%0d last=%0d, got fired=%0d index=%0d uptime=%0d last=%0d",
                     $realtime, what, want.fired, want.index, want.uptime, want.last,
                     have.fired, have.index, have.uptime, have.last);
        end
    endtask

    // Result checker: every strobed transaction is matched against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        timer_result_t have;
        timer_result_t want;
        have = '{fired, fired_index, uptime_now, last};
        if (rst_n && strobe) begin
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result", '0, have);
            end
            else begin
                want = pending_results.pop_front();
                if (want.fired !== have.fired || want.index !== have.index
                    || want.uptime !== have.uptime || want.last !== have.last) begin
                    note_mismatch("result mismatch", want, have);
                end
                if (want.last) closings_seen++;
                else expiries_seen++;
            end
        end
    end

    // Watchdog: ends the run if nothing is accepted or produced for too long.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((start && !busy) || strobe) begin
                idle_cycles <= 0;
            end
            else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout after %0d idle cycles, %0d results outstanding",
                         idle_cycles, pending_results.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        timer_cmd_t cmd;
        int n;
        for (n = 0; n < N_TIMERS; n++) begin
            bank_enable[n] = 1'b0;
            bank_notify[n] = 1'b0;
            bank_count[n]  = '0;
            bank_period[n] = '0;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < N_DIRECTED; n++) begin
            send_command(directed_rows[n]);
        end

        // Random transactions: programs of random entries interleaved with ticks.
        for (n = 0; n < N_RANDOM; n++) begin
            cmd        = '0;
            cmd.index  = INDEX_WIDTH'($urandom_range(0, N_TIMERS - 1));
            cmd.enable = ($urandom_range(0, 9) != 0);
            cmd.notify = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 99) < 45) begin
                cmd.mode   = MODE_TICK;
                cmd.count  = $urandom;
                cmd.period = $urandom;
            end
            else begin
                cmd.mode   = MODE_PROGRAM;
                cmd.count  = draw_count(8);
                cmd.period = draw_count(25);
            end
            send_command(cmd);
        end
        start <= 1'b0;

        // Drain the outstanding results, then allow for anything stray.
        while (pending_results.size() != 0) @(posedge clk);
        repeat (N_TIMERS + 8) @(posedge clk);

        $display("Sent %0d ticks and %0d program transactions.", ticks_sent, programs_sent);
        $display("Checked %0d expiry reports and %0d closing uptime results.",
                 expiries_seen, closings_seen);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end
        else begin
            $display("%0d mismatching results", mismatches);
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/tsb_pkg.sv
sv/tsb_ram.sv
sv/tsb_update.sv
sv/software_timer_bank_core.sv
sv/tsb_checker.sv
dv/tb_software_timer_bank_core.sv
